/* src/nhj_pkg.sv */
// ----------------------------------------------------------------------------
// nhj_pkg
// Shared types, constants and helpers for the note humanize jitter block.
// ----------------------------------------------------------------------------
package nhj_pkg;

	// generator constants
	localparam logic [31:0] GEN_ZERO_SEED = 32'hA5A5_A5A5;
	localparam logic [31:0] GEN_MUL       = 32'd1664525;
	localparam logic [31:0] GEN_ADD       = 32'd1013904223;

	// field widths
	localparam int DEF_SAMPLE_WIDTH = 48;
	localparam int SEED_W           = 32;
	localparam int TRANGE_W         = 20;
	localparam int VEL_W            = 7;
	localparam int SPAN_W           = TRANGE_W + 1;
	localparam int VSPAN_W          = VEL_W + 1;
	localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

	// register file
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_SEED   = 2'd0;
	localparam logic [1:0] REG_TRANGE = 2'd1;
	localparam logic [1:0] REG_VRANGE = 2'd2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// remainder unit: two quotient bits per cycle over a 32-bit draw
	localparam int MOD_STEPS = SEED_W / 2;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// classification carried with each note
	typedef struct packed {
		logic reload;
		logic do_time;
		logic do_vel;
	} jit_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_DIV,
		ST_WAIT,
		ST_APPLY,
		ST_FINISH
	} back_state_t;

	// one step of the linear congruential generator, modulo 2^32
	function automatic logic [31:0] lcg_next(input logic [31:0] w);
		return w * GEN_MUL + GEN_ADD;
	endfunction

endpackage

/* src/nhj_front.sv */
// ----------------------------------------------------------------------------
// nhj_front
// Input stage: takes a note, works out which draws it needs and pushes it
// into the queue towards the back end.
// ----------------------------------------------------------------------------
module nhj_front #(
	parameter int SAMPLE_WIDTH = nhj_pkg::DEF_SAMPLE_WIDTH,
	parameter int ENTRY_W      = SAMPLE_WIDTH + nhj_pkg::VEL_W + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_WIDTH-1:0]       start_sample,
	input  logic [nhj_pkg::VEL_W-1:0]     note_velocity,
	input  logic                          clip_start,
	input  logic [nhj_pkg::TRANGE_W-1:0]  timing_range,
	input  logic [nhj_pkg::VEL_W-1:0]     velocity_range,
	output logic                          push,
	output logic [ENTRY_W-1:0]            push_data,
	input  logic                          q_full
);
	import nhj_pkg::*;

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] start_s1;
	logic [VEL_W-1:0]        vel_s1;
	jit_flags_t              flags_s1;
	logic                    accept;

	// hold the stage while the queue is full
	assign in_stall  = valid_s1 & q_full;
	assign accept    = in_valid & ~in_stall;
	assign push      = valid_s1 & ~q_full;
	assign push_data = {flags_s1, vel_s1, start_s1};

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture and classify the note
	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1         <= start_sample;
			vel_s1           <= note_velocity;
			flags_s1.reload  <= clip_start;
			flags_s1.do_time <= (timing_range != '0);
			flags_s1.do_vel  <= (velocity_range != '0);
		end
	end

endmodule

/* src/nhj_queue.sv */
// ----------------------------------------------------------------------------
// nhj_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module nhj_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import nhj_pkg::*;

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* src/nhj_mod.sv */
// ----------------------------------------------------------------------------
// nhj_mod
// Iterative remainder unit: 32-bit draw modulo a span, two bits per cycle.
// ----------------------------------------------------------------------------
module nhj_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nhj_pkg::SEED_W-1:0]  dividend,
	input  logic [nhj_pkg::SPAN_W-1:0]  divisor,
	output logic                        done,
	output logic [nhj_pkg::SPAN_W-1:0]  remainder
);
	import nhj_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SEED_W-1:0]    dvd_q;
	logic [SPAN_W-1:0]    rem_q;
	logic [SPAN_W:0]      r1;
	logic [SPAN_W:0]      r2;

	assign done      = done_q;
	assign remainder = rem_q;

	// two restoring steps
	always_comb begin
		r1 = {rem_q, dvd_q[SEED_W-1]};
		if (r1 >= {1'b0, divisor}) begin
			r1 = r1 - {1'b0, divisor};
		end
		r2 = {r1[SPAN_W-1:0], dvd_q[SEED_W-2]};
		if (r2 >= {1'b0, divisor}) begin
			r2 = r2 - {1'b0, divisor};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SEED_W-3:0], 2'b00};
			rem_q <= r2[SPAN_W-1:0];
		end
	end

endmodule

/* src/nhj_back.sv */
// ----------------------------------------------------------------------------
// nhj_back
// Back end: runs the generator, applies timing and velocity offsets and
// holds the finished note in the output register.
// ----------------------------------------------------------------------------
module nhj_back #(
	parameter int SAMPLE_WIDTH = nhj_pkg::DEF_SAMPLE_WIDTH,
	parameter int ENTRY_W      = SAMPLE_WIDTH + nhj_pkg::VEL_W + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ENTRY_W-1:0]            pop_data,
	input  logic                          q_empty,
	output logic                          pop,
	input  logic [nhj_pkg::SEED_W-1:0]    seed_value,
	input  logic [nhj_pkg::TRANGE_W-1:0]  timing_range,
	input  logic [nhj_pkg::VEL_W-1:0]     velocity_range,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [SAMPLE_WIDTH-1:0]       new_start_sample,
	output logic [nhj_pkg::VEL_W-1:0]     new_velocity
);
	import nhj_pkg::*;

	localparam int VEL_LO = SAMPLE_WIDTH;
	localparam int FLG_LO = SAMPLE_WIDTH + VEL_W;

	back_state_t             state_q;
	back_state_t             state_d;
	logic                    phase_q;
	logic [SEED_W-1:0]       gen_q;
	logic [SAMPLE_WIDTH-1:0] start_q;
	logic [VEL_W-1:0]        vel_q;
	jit_flags_t              flags_q;
	jit_flags_t              in_flags;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_start_q;
	logic [VEL_W-1:0]        out_vel_q;
	logic                    out_free;

	logic                    mod_start;
	logic                    mod_done;
	logic [SPAN_W-1:0]       mod_rem;
	logic [SPAN_W-1:0]       divisor;

	logic [SPAN_W-1:0]       r_ext;
	logic [SAMPLE_WIDTH:0]   sum_up;
	logic [SAMPLE_WIDTH:0]   diff_dn;
	logic [SAMPLE_WIDTH-1:0] start_adj;
	logic [VEL_W+1:0]        vtmp;
	logic [VEL_W+1:0]        vdiff;
	logic [VEL_W-1:0]        vel_adj;

	assign in_flags  = pop_data[ENTRY_W-1:FLG_LO];
	assign pop       = (state_q == ST_IDLE) & ~q_empty;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign mod_start = (state_q == ST_DIV);

	assign out_valid        = out_valid_q;
	assign new_start_sample = out_start_q;
	assign new_velocity     = out_vel_q;

	// span 2R+1 for the draw in hand
	assign divisor = phase_q ? {{(SPAN_W-VSPAN_W){1'b0}}, velocity_range, 1'b1}
	                         : {timing_range, 1'b1};

	nhj_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (gen_q),
		.divisor   (divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// timing offset, clamped at zero and saturated at the field maximum
	always_comb begin
		r_ext   = {1'b0, timing_range};
		sum_up  = {1'b0, start_q} + (SAMPLE_WIDTH+1)'(mod_rem - r_ext);
		diff_dn = {1'b0, start_q} - (SAMPLE_WIDTH+1)'(r_ext - mod_rem);
		if (mod_rem >= r_ext) begin
			start_adj = sum_up[SAMPLE_WIDTH] ? '1 : sum_up[SAMPLE_WIDTH-1:0];
		end else begin
			start_adj = diff_dn[SAMPLE_WIDTH] ? '0 : diff_dn[SAMPLE_WIDTH-1:0];
		end
	end

	// velocity offset, clamped to the seven-bit range
	always_comb begin
		vtmp  = {2'b00, vel_q} + {1'b0, mod_rem[VSPAN_W-1:0]};
		vdiff = vtmp - {2'b00, velocity_range};
		if (vtmp < {2'b00, velocity_range}) begin
			vel_adj = '0;
		end else if (vdiff > {2'b00, VEL_MAX}) begin
			vel_adj = VEL_MAX;
		end else begin
			vel_adj = vdiff[VEL_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (in_flags.do_time || in_flags.do_vel) begin
						state_d = ST_DRAW;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DRAW:  state_d = ST_DIV;
			ST_DIV:   state_d = ST_WAIT;
			ST_WAIT: begin
				if (mod_done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (!phase_q && flags_q.do_vel) begin
					state_d = ST_DRAW;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// generator, phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= GEN_ZERO_SEED;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= ~in_flags.do_time;
				if (in_flags.reload) begin
					gen_q <= (seed_value == '0) ? GEN_ZERO_SEED : seed_value;
				end
			end else if (state_q == ST_DRAW) begin
				gen_q <= lcg_next(gen_q);
			end else if (state_q == ST_APPLY) begin
				phase_q <= 1'b1;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working note and output register
	always_ff @(posedge clk) begin
		if (pop) begin
			start_q <= pop_data[SAMPLE_WIDTH-1:0];
			vel_q   <= pop_data[FLG_LO-1:VEL_LO];
			flags_q <= in_flags;
		end else if (state_q == ST_APPLY) begin
			if (phase_q) begin
				vel_q <= vel_adj;
			end else begin
				start_q <= start_adj;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_start_q <= start_q;
			out_vel_q   <= vel_q;
		end
	end

endmodule

/* src/note_humanize_jitter.sv */
// ----------------------------------------------------------------------------
// note_humanize_jitter
// Random humanisation of note start and velocity from a 32-bit linear
// congruential generator, reseeded at the first note of each clip.
//
//   channel  direction  handshake              transaction payload
//   in       input      in_valid / in_stall    start_sample, note_velocity,
//                                              clip_start
//   out      output     out_valid / out_stall  new_start_sample, new_velocity
//   cfg      input      APB psel/penable       seed, timing and velocity range
//
// A note with no jitter skips the draws; each enabled range takes one draw
// through the two-bit-per-cycle remainder unit.
// Reset is asynchronous: generator to 0xA5A5A5A5, registers to zero.
// The back end, a two-entry queue and an input stage take up to four
// further notes while a finished note waits in the output register.
// ----------------------------------------------------------------------------
module note_humanize_jitter #(
	parameter int SAMPLE_WIDTH = nhj_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// note input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_WIDTH-1:0]       start_sample,
	input  logic [nhj_pkg::VEL_W-1:0]     note_velocity,
	input  logic                          clip_start,
	// note output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [SAMPLE_WIDTH-1:0]       new_start_sample,
	output logic [nhj_pkg::VEL_W-1:0]     new_velocity,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nhj_pkg::ADDR_W-1:0]    paddr,
	input  logic [nhj_pkg::DATA_W-1:0]    pwdata,
	output logic [nhj_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import nhj_pkg::*;

	localparam int ENTRY_W = SAMPLE_WIDTH + VEL_W + $bits(jit_flags_t);

	logic [SEED_W-1:0]   seed_q;
	logic [TRANGE_W-1:0] trange_q;
	logic [VEL_W-1:0]    vrange_q;
	logic [1:0]          reg_idx;
	logic                cfg_write;

	logic                push;
	logic [ENTRY_W-1:0]  push_data;
	logic                pop;
	logic [ENTRY_W-1:0]  pop_data;
	logic                q_full;
	logic                q_empty;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			trange_q <= '0;
			vrange_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_SEED:   seed_q   <= pwdata;
				REG_TRANGE: trange_q <= pwdata[TRANGE_W-1:0];
				REG_VRANGE: vrange_q <= pwdata[VEL_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_SEED:   prdata = seed_q;
			REG_TRANGE: prdata = {{(DATA_W-TRANGE_W){1'b0}}, trange_q};
			REG_VRANGE: prdata = {{(DATA_W-VEL_W){1'b0}}, vrange_q};
			default:    prdata = '0;
		endcase
	end

	nhj_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_sample   (start_sample),
		.note_velocity  (note_velocity),
		.clip_start     (clip_start),
		.timing_range   (trange_q),
		.velocity_range (vrange_q),
		.push           (push),
		.push_data      (push_data),
		.q_full         (q_full)
	);

	nhj_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	nhj_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_data         (pop_data),
		.q_empty          (q_empty),
		.pop              (pop),
		.seed_value       (seed_q),
		.timing_range     (trange_q),
		.velocity_range   (vrange_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.new_start_sample (new_start_sample),
		.new_velocity     (new_velocity)
	);

endmodule

/* src/nhj_checker.sv */
// ----------------------------------------------------------------------------
// nhj_checker
// Port-level checks for the note humanize jitter block, bound to the top.
// ----------------------------------------------------------------------------
module nhj_checker #(
	parameter int SAMPLE_WIDTH = nhj_pkg::DEF_SAMPLE_WIDTH
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [SAMPLE_WIDTH-1:0]   new_start_sample,
	input logic [nhj_pkg::VEL_W-1:0] new_velocity,
	input logic                      pready
);
	import nhj_pkg::*;

	// input stage, queue, back end and output register
	localparam int CAPACITY = QUEUE_DEPTH + 3;
	localparam int PEND_W   = $clog2(CAPACITY + 1) + 1;

	logic              in_acc;
	logic              out_acc;
	logic [PEND_W-1:0] pending_q;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	// notes taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_start_sample)
			&& $stable(new_velocity))
		else $error("output transaction changed while stalled");

	// a result withdrawn only once taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output transaction dropped without acceptance");

	// no result without a note behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("output transaction with no note outstanding");

	// the block never holds more notes than it has room for
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_W'(CAPACITY))
		else $error("more notes taken than the block can hold");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port not ready");

endmodule

bind note_humanize_jitter nhj_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_nhj_checker (.*);

/* sim/note_humanize_jitter_test.sv */
// ----------------------------------------------------------------------------
// note_humanize_jitter_test
// Self-checking bench for the note humanize jitter block. Notes go in through
// a queue-fed driver with random gaps, results are taken with random stalls
// and compared field by field against an in-bench generator and jitter
// predictor. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module note_humanize_jitter_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW       = nhj_pkg::DEF_SAMPLE_WIDTH;
	localparam int VW       = nhj_pkg::VEL_W;
	localparam int CLK_HALF = 5;

	localparam logic [SW-1:0] SAMPLE_MAX     = {SW{1'b1}};
	localparam logic [31:0]   ZERO_SEED_WORD = 32'hA5A5_A5A5;
	localparam logic [31:0]   LCG_MUL        = 32'd1664525;
	localparam logic [31:0]   LCG_ADD        = 32'd1013904223;
	localparam int            VEL_TOP        = 127;
	localparam logic [19:0]   TRANGE_TOP     = 20'hF_FFFF;
	// register index past the end of the map, writes to it are dropped
	localparam logic [1:0]    REG_SPARE      = 2'd3;

	typedef struct packed {
		logic [SW-1:0] start;
		logic [VW-1:0] vel;
		logic          clip;
	} note_t;

	typedef struct packed {
		logic [SW-1:0] start;
		logic [VW-1:0] vel;
	} placed_t;

	// block ports
	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        in_valid      = 1'b0;
	logic                        in_stall;
	logic [SW-1:0]               start_sample  = '0;
	logic [VW-1:0]               note_velocity = '0;
	logic                        clip_start    = 1'b0;
	logic                        out_valid;
	logic                        out_stall     = 1'b0;
	logic [SW-1:0]               new_start_sample;
	logic [VW-1:0]               new_velocity;
	logic                        psel          = 1'b0;
	logic                        penable       = 1'b0;
	logic                        pwrite        = 1'b0;
	logic [nhj_pkg::ADDR_W-1:0]  paddr         = '0;
	logic [nhj_pkg::DATA_W-1:0]  pwdata        = '0;
	logic [nhj_pkg::DATA_W-1:0]  prdata;
	logic                        pready;

	// predictor state and register copies
	logic [31:0] gen_word   = ZERO_SEED_WORD;
	logic [31:0] seed_reg   = '0;
	logic [19:0] trange_reg = '0;
	logic [6:0]  vrange_reg = '0;

	// pending notes and expected placements
	note_t       note_q[$];
	placed_t     note_expect[$];

	// handshake bookkeeping between the edges
	bit          note_taken  = 1'b0;
	int unsigned note_gap    = 0;
	int unsigned result_wait = 0;
	int unsigned in_calm     = 0;
	int unsigned out_calm    = 0;
	int unsigned fault_count = 0;

	note_humanize_jitter #(
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_sample(start_sample),
		.note_velocity(note_velocity),
		.clip_start(clip_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_start_sample(new_start_sample),
		.new_velocity(new_velocity),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_HALF) clk = ~clk;

	// one generator step, modulo 2^32
	function automatic logic [31:0] next_draw();
		gen_word = gen_word * LCG_MUL + LCG_ADD;
		return gen_word;
	endfunction

	// jittered placement of one note, advancing the generator
	function automatic placed_t place_note(logic [SW-1:0] start, logic [VW-1:0] vel, logic clip);
		placed_t     res;
		logic [31:0] span;
		logic [31:0] m;
		logic [SW-1:0] d;
		int          v;
		if (clip) begin
			gen_word = (seed_reg == 0) ? ZERO_SEED_WORD : seed_reg;
		end
		res.start = start;
		res.vel   = vel;
		if (trange_reg != 0) begin
			span = 2 * trange_reg + 1;
			m    = next_draw() % span;
			if (m >= trange_reg) begin
				d = SW'(m - trange_reg);
				res.start = (d > SAMPLE_MAX - start) ? SAMPLE_MAX : start + d;
			end else begin
				d = SW'(trange_reg - m);
				res.start = (d > start) ? '0 : start - d;
			end
		end
		if (vrange_reg != 0) begin
			span = 2 * vrange_reg + 1;
			v = int'(vel) + int'(next_draw() % span) - int'(vrange_reg);
			if (v < 0)
				v = 0;
			if (v > VEL_TOP)
				v = VEL_TOP;
			res.vel = v[VW-1:0];
		end
		return res;
	endfunction

	// idle cycles before the next transaction, with quiet stretches now and then
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [SW-1:0] pick_start(logic [19:0] reach);
		logic [SW-1:0] near;
		near = SW'($urandom_range(0, 2 * reach + 2));
		case ($urandom_range(0, 5))
			0: return near;
			1: return SAMPLE_MAX - near;
			default: return SW'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [VW-1:0] pick_velocity();
		case ($urandom_range(0, 4))
			0: return VW'($urandom_range(0, 3));
			1: return VW'(VEL_TOP - $urandom_range(0, 3));
			default: return VW'($urandom_range(0, VEL_TOP));
		endcase
	endfunction

	function automatic logic [31:0] pick_seed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [19:0] pick_trange();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 20'd1;
			2: return TRANGE_TOP;
			3: return 20'($urandom_range(2, 64));
			default: return 20'($urandom_range(0, TRANGE_TOP));
		endcase
	endfunction

	function automatic logic [6:0] pick_vrange();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 7'd1;
			2: return 7'(VEL_TOP);
			default: return 7'($urandom_range(2, VEL_TOP - 1));
		endcase
	endfunction

	task automatic add_note(logic [SW-1:0] start, logic [VW-1:0] vel, logic clip);
		note_t n;
		n.start = start;
		n.vel   = vel;
		n.clip  = clip;
		note_q = {note_q, n};
	endtask

	// register write, setup then access phase
	task automatic set_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			nhj_pkg::REG_SEED:   seed_reg   = value;
			nhj_pkg::REG_TRANGE: trange_reg = value[19:0];
			nhj_pkg::REG_VRANGE: vrange_reg = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// block idle: nothing queued, nothing offered, nothing outstanding
	task automatic wait_settled();
		while (note_q.size() != 0 || in_valid || note_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// note driver: offers the next queued note after its gap
	always @(negedge clk) begin : drive_notes
		logic  nxt_valid;
		note_t nxt;
		nxt_valid = in_valid;
		if (arst_n) begin
			if (note_taken) begin
				note_taken = 1'b0;
				nxt_valid  = 1'b0;
				note_gap   = draw_wait(in_calm);
			end
			if (!nxt_valid) begin
				if (note_gap != 0) begin
					note_gap--;
				end else if (note_q.size() != 0) begin
					nxt = note_q.pop_front();
					start_sample  <= nxt.start;
					note_velocity <= nxt.vel;
					clip_start    <= nxt.clip;
					nxt_valid     = 1'b1;
				end
			end
		end
		in_valid <= nxt_valid;
	end

	// result stall: held while a drawn number of valid cycles runs out
	always @(negedge clk) begin
		if (arst_n && result_wait != 0) begin
			out_stall <= 1'b1;
			if (out_valid)
				result_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: predict on each note transaction, check each result transaction
	always @(posedge clk) begin : watch_channels
		placed_t want;
		if (arst_n && in_valid && !in_stall) begin
			note_expect = {note_expect, place_note(start_sample, note_velocity, clip_start)};
			note_taken = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			result_wait = draw_wait(out_calm);
			if (note_expect.size() == 0) begin
				if (fault_count < 10)
					$display("unexpected result: start %h velocity %0d",
						new_start_sample, new_velocity);
				fault_count++;
			end else begin
				want = note_expect.pop_front();
				if (want.start !== new_start_sample || want.vel !== new_velocity) begin
					if (fault_count < 10)
						$display("mismatch: start exp %h got %h, velocity exp %0d got %0d",
							want.start, new_start_sample, want.vel, new_velocity);
					fault_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned count;
		logic [31:0] seed_pick;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers at reset: notes pass straight through
		add_note('0, '0, 1'b0);
		add_note(SAMPLE_MAX, 7'd127, 1'b0);
		add_note(SW'({$urandom(), $urandom()}), 7'd64, 1'b0);
		wait_settled();

		// widest ranges, generator still running from its reset word
		set_reg(nhj_pkg::REG_TRANGE, 32'(TRANGE_TOP));
		set_reg(nhj_pkg::REG_VRANGE, 32'd127);
		add_note('0, '0, 1'b0);
		add_note(SAMPLE_MAX, 7'd127, 1'b0);
		add_note(SW'(5), 7'd3, 1'b0);
		add_note(SAMPLE_MAX - 5, 7'd125, 1'b0);
		// clip start with a zero seed takes the fixed word
		add_note(SW'(1000), 7'd64, 1'b1);
		add_note({1'b1, {(SW-1){1'b0}}}, 7'd100, 1'b0);
		wait_settled();

		// timing only, smallest range, all-ones seed
		set_reg(nhj_pkg::REG_SEED, 32'hFFFF_FFFF);
		set_reg(nhj_pkg::REG_TRANGE, 32'd1);
		set_reg(nhj_pkg::REG_VRANGE, 32'd0);
		add_note('0, 7'd127, 1'b1);
		add_note(SAMPLE_MAX, '0, 1'b0);
		add_note(SW'(1), 7'd5, 1'b0);
		add_note(SAMPLE_MAX - 1, 7'd5, 1'b0);
		wait_settled();

		// velocity only
		set_reg(nhj_pkg::REG_SEED, $urandom());
		set_reg(nhj_pkg::REG_TRANGE, 32'd0);
		set_reg(nhj_pkg::REG_VRANGE, 32'd1);
		add_note(SW'(123), '0, 1'b1);
		add_note(SW'(456), 7'd127, 1'b0);
		add_note(SW'(789), 7'd1, 1'b0);
		wait_settled();

		// both off: clip start still reloads the generator
		set_reg(nhj_pkg::REG_VRANGE, 32'd0);
		set_reg(nhj_pkg::REG_SEED, 32'h1234_5678);
		set_reg(REG_SPARE, $urandom());
		add_note(SAMPLE_MAX, 7'd127, 1'b1);
		wait_settled();
		set_reg(nhj_pkg::REG_TRANGE, 32'd3);
		set_reg(nhj_pkg::REG_VRANGE, 32'd127);
		add_note(SW'(2), '0, 1'b0);
		add_note(SAMPLE_MAX - 2, 7'd127, 1'b0);
		wait_settled();

		// random phases: clips of random notes under random settings
		for (int ph = 0; ph < 10; ph++) begin
			seed_pick = pick_seed();
			set_reg(nhj_pkg::REG_SEED, seed_pick);
			set_reg(nhj_pkg::REG_TRANGE, 32'(pick_trange()));
			set_reg(nhj_pkg::REG_VRANGE, 32'(pick_vrange()));
			if ($urandom_range(0, 7) == 0)
				set_reg(REG_SPARE, $urandom());
			count = $urandom_range(100, 120);
			for (int i = 0; i < count; i++) begin
				add_note(pick_start(trange_reg), pick_velocity(),
					(i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0));
			end
			wait_settled();
		end

		repeat (50) @(posedge clk);
		if (note_expect.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule
